// ----- rtl/dac_pkg.sv -----
// ----------------------------------------------------------------------------
// dac_pkg
// Shared constants and types for the decimal accumulator with carry cut.
// ----------------------------------------------------------------------------
`default_nettype none

package dac_pkg;

   localparam int NUM_COLUMNS = 10;
   localparam int DIGIT_W     = 4;
   localparam int CARRY_W     = 2;
   localparam int SUM_W       = 5;
   localparam int KEYS_W      = NUM_COLUMNS * DIGIT_W;
   localparam int TOTAL_W     = (NUM_COLUMNS + 1) * DIGIT_W;

   localparam logic [SUM_W-1:0]   RADIX        = SUM_W'(10);
   localparam logic [SUM_W-1:0]   RADIX_TWICE  = SUM_W'(20);
   localparam logic [SUM_W-1:0]   OVERFLOW_MAX = SUM_W'(15);
   localparam logic [DIGIT_W-1:0] FLAG_LIMIT   = DIGIT_W'(9);

   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   typedef struct packed {
      logic clear;
      logic load;
   } cell_ctrl_type;

endpackage : dac_pkg

`default_nettype wire

// ----- rtl/dac_req_if.sv -----
// ----------------------------------------------------------------------------
// dac_req_if
// Request channel: action, column keys and carry cut mask.
// ----------------------------------------------------------------------------
`default_nettype none

interface dac_req_if
   import dac_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic                   action;
   logic [KEYS_W-1:0]      key_col;
   logic [NUM_COLUMNS-1:0] carry_cut_mask;

   modport source (output valid, output action, output key_col,
                   output carry_cut_mask, input ready);
   modport sink   (input valid, input action, input key_col,
                   input carry_cut_mask, output ready);
endinterface : dac_req_if

`default_nettype wire

// ----- rtl/dac_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dac_rsp_if
// Response channel: packed BCD total and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dac_rsp_if
   import dac_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] total_bcd;
   logic               top_overflow;

   modport source (output valid, output total_bcd, output top_overflow,
                   input ready);
   modport sink   (input valid, input total_bcd, input top_overflow,
                   output ready);
endinterface : dac_rsp_if

`default_nettype wire

// ----- rtl/dac_digit_cell.sv -----
// ----------------------------------------------------------------------------
// dac_digit_cell
// One decimal column: holds its digit, adds key and carry when the token
// passes, and hands token and carry to the next more significant column.
// ----------------------------------------------------------------------------
`default_nettype none

module dac_digit_cell
   import dac_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [DIGIT_W-1:0]  key_in,
   input  wire logic                cut_in,
   input  wire logic                token_in,
   input  wire logic [CARRY_W-1:0]  carry_in,
   output logic                     token_out,
   output logic [CARRY_W-1:0]       carry_out,
   output logic [DIGIT_W-1:0]       digit_out
);

   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [DIGIT_W-1:0] key_ff;
   logic               cut_ff;
   logic               token_ff;
   logic [CARRY_W-1:0] carry_ff, carry_in_next;
   logic [SUM_W-1:0]   sum;

   always_comb begin
      sum = SUM_W'(digit_ff) + SUM_W'(key_ff) + SUM_W'(carry_in);
      if (sum >= RADIX_TWICE) begin
         digit_in      = DIGIT_W'(sum - RADIX_TWICE);
         carry_in_next = CARRY_W'(2);
      end else if (sum >= RADIX) begin
         digit_in      = DIGIT_W'(sum - RADIX);
         carry_in_next = CARRY_W'(1);
      end else begin
         digit_in      = DIGIT_W'(sum);
         carry_in_next = '0;
      end
      if (cut_ff) begin
         carry_in_next = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         digit_ff <= '0;
         token_ff <= 1'b0;
         carry_ff <= '0;
      end else if (ctrl.load) begin
         token_ff <= 1'b0;
         carry_ff <= '0;
      end else begin
         token_ff <= token_in;
         if (token_in) begin
            digit_ff <= digit_in;
            carry_ff <= carry_in_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         key_ff <= key_in;
         cut_ff <= cut_in;
      end
   end

   assign token_out = token_ff;
   assign carry_out = carry_ff;
   assign digit_out = digit_ff;

endmodule : dac_digit_cell

`default_nettype wire

// ----- rtl/dac_overflow_cell.sv -----
// ----------------------------------------------------------------------------
// dac_overflow_cell
// Overflow digit at the top of the chain: takes the carry out of the most
// significant column, saturates, and marks the end of the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dac_overflow_cell
   import dac_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic                token_in,
   input  wire logic [CARRY_W-1:0]  carry_in,
   output logic                     done,
   output logic [DIGIT_W-1:0]       digit_out
);

   logic [DIGIT_W-1:0] ov_ff, ov_in;
   logic               done_ff;
   logic [SUM_W-1:0]   sum;

   always_comb begin
      sum = SUM_W'(ov_ff) + SUM_W'(carry_in);
      ov_in = (sum > OVERFLOW_MAX) ? DIGIT_W'(OVERFLOW_MAX) : DIGIT_W'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         ov_ff   <= '0;
         done_ff <= 1'b0;
      end else if (ctrl.load) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= token_in;
         if (token_in) begin
            ov_ff <= ov_in;
         end
      end
   end

   assign done      = done_ff;
   assign digit_out = ov_ff;

endmodule : dac_overflow_cell

`default_nettype wire

// ----- rtl/decimal_accumulator_carry_cut_core.sv -----
// ----------------------------------------------------------------------------
// decimal_accumulator_carry_cut_core
// Decimal adding-machine accumulator: a chain of digit cells that ripples
// the carry one column per cycle, with per-column carry cut and a
// saturating overflow digit.
//
//   channel   dir   payload                                  handshake
//   req_port  in    action, key_col, carry_cut_mask          valid/ready
//   rsp_port  out   total_bcd, top_overflow                  valid/ready
//
// Add: the carry token walks the cell chain column by column from the least
// significant, then reaches the overflow digit, and the result is captured
// in the response register. Clear: zeroes the digits and reports the total.
// Reset is synchronous and zeroes every digit and the overflow digit.
// A new request is taken once the last result is in the response register,
// even while it still waits; a stalled response keeps the block in STATE_HOLD.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_accumulator_carry_cut_core
   import dac_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   dac_req_if.sink    req_port,
   dac_rsp_if.source  rsp_port
);

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_START,
      STATE_RUN,
      STATE_HOLD
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] total_ff;
   logic               flag_ff;

   cell_ctrl_type      ctrl;
   logic               accept;
   logic               ov_done;
   logic               rsp_free;
   logic               load_out;
   logic [TOTAL_W-1:0] packed_total;
   logic               packed_flag;
   logic [DIGIT_W-1:0] ov_digit;

   logic                     token_chain [NUM_COLUMNS+1];
   logic [CARRY_W-1:0]       carry_chain [NUM_COLUMNS+1];
   logic [DIGIT_W-1:0]       digits      [NUM_COLUMNS];
   logic [NUM_COLUMNS-1:0]   tokens;

   assign req_port.ready = (state_ff == STATE_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign ctrl.clear     = accept && (req_port.action == ACTION_CLEAR);
   assign ctrl.load      = accept && (req_port.action == ACTION_ADD);

   assign token_chain[NUM_COLUMNS] = (state_ff == STATE_START);
   assign carry_chain[NUM_COLUMNS] = '0;

   for (genvar i = 0; i < NUM_COLUMNS; i++) begin : g_cell
      dac_digit_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .key_in    (req_port.key_col[i*DIGIT_W +: DIGIT_W]),
         .cut_in    (req_port.carry_cut_mask[i]),
         .token_in  (token_chain[i+1]),
         .carry_in  (carry_chain[i+1]),
         .token_out (token_chain[i]),
         .carry_out (carry_chain[i]),
         .digit_out (digits[i])
      );
      assign tokens[i] = token_chain[i];
   end

   dac_overflow_cell u_overflow (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .token_in  (token_chain[0]),
      .carry_in  (carry_chain[0]),
      .done      (ov_done),
      .digit_out (ov_digit)
   );

   always_comb begin
      packed_total = '0;
      for (int j = 0; j < NUM_COLUMNS; j++) begin
         packed_total[j*DIGIT_W +: DIGIT_W] = digits[NUM_COLUMNS-1-j];
      end
      packed_total[NUM_COLUMNS*DIGIT_W +: DIGIT_W] = ov_digit;
      packed_flag = (ov_digit > FLAG_LIMIT);
   end

   assign rsp_free = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      state_in     = state_ff;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      unique case (state_ff)
         STATE_IDLE: begin
            if (ctrl.clear) begin
               state_in = STATE_HOLD;
            end else if (ctrl.load) begin
               state_in = STATE_START;
            end
         end
         STATE_START: begin
            state_in = STATE_RUN;
         end
         STATE_RUN: begin
            if (ov_done) begin
               if (rsp_free) begin
                  load_out = 1'b1;
                  state_in = STATE_IDLE;
               end else begin
                  state_in = STATE_HOLD;
               end
            end
         end
         STATE_HOLD: begin
            if (rsp_free) begin
               load_out = 1'b1;
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_out) begin
         total_ff <= packed_total;
         flag_ff  <= packed_flag;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.total_bcd    = total_ff;
   assign rsp_port.top_overflow = flag_ff;

   a_token_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tokens))
      else $error("more than one column holds the carry token");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      ov_done |-> (state_ff == STATE_RUN))
      else $error("overflow digit finished outside of an add pass");

   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (flag_ff == (total_ff[NUM_COLUMNS*DIGIT_W +: DIGIT_W] > FLAG_LIMIT)))
      else $error("overflow flag disagrees with the overflow digit");

   a_add_starts_chain: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> token_chain[NUM_COLUMNS])
      else $error("add transfer did not launch the carry token");

endmodule : decimal_accumulator_carry_cut_core

`default_nettype wire

// ----- tb/decimal_accumulator_carry_cut_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_accumulator_carry_cut_checker
// Watches both channels of the decimal accumulator. Every request transfer
// updates a private copy of the digit register and queues the total the
// block should report. Every response transfer is compared against the
// oldest queued total.
// ----------------------------------------------------------------------------

module decimal_accumulator_carry_cut_checker
   import dac_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   dac_req_if        req_mon,
   dac_rsp_if        rsp_mon,
   output int        mismatch_count,
   output int        pending_count,
   output int        checked_count
);

   typedef struct packed {
      logic [TOTAL_W-1:0] total_bcd;
      logic               top_overflow;
   } bcd_total_type;

   logic [DIGIT_W-1:0] digit_reg [NUM_COLUMNS];
   logic [DIGIT_W-1:0] overflow_reg;
   bcd_total_type      pending_totals [$];
   bcd_total_type      want;
   int                 errors = 0;
   int                 checked = 0;

   function automatic void clear_digits();
      for (int col = 0; col < NUM_COLUMNS; col++) digit_reg[col] = '0;
      overflow_reg = '0;
   endfunction

   // Column i's key sits in key_col[DIGIT_W*i +: DIGIT_W]; column 0 is the top.
   function automatic bcd_total_type accumulate_keys(input logic act,
                                                     input logic [KEYS_W-1:0] keys,
                                                     input logic [NUM_COLUMNS-1:0] mask);
      logic [SUM_W-1:0] col_sum;
      logic [SUM_W-1:0] carry;
      logic [SUM_W-1:0] ov_sum;
      bcd_total_type    res;
      if (act == ACTION_CLEAR) begin
         clear_digits();
      end else begin
         carry = '0;
         for (int col = NUM_COLUMNS - 1; col >= 0; col--) begin
            col_sum = SUM_W'(digit_reg[col]) + SUM_W'(keys[DIGIT_W*col +: DIGIT_W]) + carry;
            digit_reg[col] = DIGIT_W'(col_sum % RADIX);
            carry = col_sum / RADIX;
            if (mask[col]) carry = '0;
         end
         ov_sum = SUM_W'(overflow_reg) + carry;
         if (ov_sum > OVERFLOW_MAX) ov_sum = OVERFLOW_MAX;
         overflow_reg = DIGIT_W'(ov_sum);
      end
      res.total_bcd = '0;
      for (int col = 0; col < NUM_COLUMNS; col++)
         res.total_bcd[DIGIT_W*(NUM_COLUMNS-1-col) +: DIGIT_W] = digit_reg[col];
      res.total_bcd[TOTAL_W-1 -: DIGIT_W] = overflow_reg;
      res.top_overflow = (overflow_reg > FLAG_LIMIT);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_digits();
         pending_totals.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            pending_totals.push_back(accumulate_keys(req_mon.action, req_mon.key_col,
                                                     req_mon.carry_cut_mask));
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked++;
            if (pending_totals.size() == 0) begin
               errors++;
               $display("%0t: unexpected response total_bcd=%h top_overflow=%b",
                        $time, rsp_mon.total_bcd, rsp_mon.top_overflow);
            end else begin
               want = pending_totals.pop_front();
               if (rsp_mon.total_bcd !== want.total_bcd) begin
                  errors++;
                  $display("%0t: total_bcd mismatch, expected %h, actual %h",
                           $time, want.total_bcd, rsp_mon.total_bcd);
               end
               if (rsp_mon.top_overflow !== want.top_overflow) begin
                  errors++;
                  $display("%0t: top_overflow mismatch, expected %b, actual %b",
                           $time, want.top_overflow, rsp_mon.top_overflow);
               end
            end
         end
      end
      pending_count  <= pending_totals.size();
      mismatch_count <= errors;
      checked_count  <= checked;
   end

endmodule : decimal_accumulator_carry_cut_checker

// ----- tb/decimal_accumulator_carry_cut_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_accumulator_carry_cut_core_tb
// Drives adds and clears into the decimal accumulator: a directed set
// covering saturation, carry cut and oversized keys, then random items in
// three flow-control phases. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------

module decimal_accumulator_carry_cut_core_tb;
   import dac_pkg::*;

   localparam int RANDOM_ITEMS = 1200;

   logic clock = 1'b0;
   logic reset;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   int   sent_count = 0;
   int   clear_count = 0;
   int   mismatch_count;
   int   pending_count;
   int   checked_count;

   dac_req_if req_if ();
   dac_rsp_if rsp_if ();

   decimal_accumulator_carry_cut_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   decimal_accumulator_carry_cut_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   initial begin
      #5ms;
      $display("decimal_accumulator_carry_cut_core regression: fail");
      $finish;
   end

   task automatic send_item(input logic act, input logic [KEYS_W-1:0] keys,
                            input logic [NUM_COLUMNS-1:0] mask);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.action         <= act;
      req_if.key_col        <= keys;
      req_if.carry_cut_mask <= mask;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
      if (act == ACTION_CLEAR) clear_count++;
   endtask

   task automatic send_random_item();
      logic [KEYS_W-1:0]      keys;
      logic [NUM_COLUMNS-1:0] mask;
      int                     style;
      style = $urandom_range(99);
      keys  = '0;
      for (int col = 0; col < NUM_COLUMNS; col++) begin
         if (style >= 20 || $urandom_range(3) == 0) begin
            if ($urandom_range(9) == 0)
               keys[DIGIT_W*col +: DIGIT_W] = DIGIT_W'($urandom_range(15, 11));
            else
               keys[DIGIT_W*col +: DIGIT_W] = DIGIT_W'($urandom_range(10));
         end
      end
      case ($urandom_range(3))
         0: mask = '0;
         1: mask = NUM_COLUMNS'($urandom());
         2: mask = NUM_COLUMNS'(1) << $urandom_range(NUM_COLUMNS - 1);
         default: mask = ($urandom_range(1) == 0) ? '1 : '0;
      endcase
      send_item((style < 4) ? ACTION_CLEAR : ACTION_ADD, keys, mask);
   endtask

   initial begin
      logic [KEYS_W-1:0] ramp;
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.action         = ACTION_ADD;
      req_if.key_col        = '0;
      req_if.carry_cut_mask = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: ripple through all nines, oversized keys, cut, saturation
      send_item(ACTION_CLEAR, '0, '0);
      send_item(ACTION_ADD, '0, '0);
      send_item(ACTION_ADD, {NUM_COLUMNS{4'd9}}, '0);
      send_item(ACTION_ADD, KEYS_W'(1) << (DIGIT_W*(NUM_COLUMNS-1)), '0);
      send_item(ACTION_ADD, {NUM_COLUMNS{4'd15}}, '1);
      repeat (8) send_item(ACTION_ADD, {NUM_COLUMNS{4'd15}}, '0);
      send_item(ACTION_ADD, {NUM_COLUMNS{4'd10}}, '1);
      send_item(ACTION_CLEAR, {NUM_COLUMNS{4'd15}}, '1);
      send_item(ACTION_ADD, {NUM_COLUMNS{4'd10}}, NUM_COLUMNS'(10'h155));
      send_item(ACTION_ADD, {NUM_COLUMNS{4'd10}}, NUM_COLUMNS'(10'h2AA));
      send_item(ACTION_ADD, KEYS_W'(10), '0);
      for (int col = 0; col < NUM_COLUMNS; col++)
         ramp[DIGIT_W*col +: DIGIT_W] = DIGIT_W'(col);
      send_item(ACTION_ADD, ramp, '0);
      repeat (2) send_item(ACTION_ADD, {NUM_COLUMNS{4'd5}}, '0);
      send_item(ACTION_CLEAR, '0, '0);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 48 : 0;
         rsp_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 23 : 0;
         repeat (RANDOM_ITEMS / 3) send_random_item();
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (NUM_COLUMNS + 8) @(posedge clock);

      $display("Sent %0d requests (%0d clears), checked %0d totals against the predictor.",
               sent_count, clear_count, checked_count);
      $display("Directed ripple, cut and saturation cases, random keys 0..15, three stall mixes.");
      if (mismatch_count == 0)
         $display("decimal_accumulator_carry_cut_core regression: pass");
      else
         $display("decimal_accumulator_carry_cut_core regression: fail");
      $finish;
   end

endmodule : decimal_accumulator_carry_cut_core_tb
